/* rtl/text_screen_selection_overlay_assert.svh */
// Assertion macros used by the overlay datapath.
`ifndef TEXT_SCREEN_SELECTION_OVERLAY_ASSERT_SVH
`define TEXT_SCREEN_SELECTION_OVERLAY_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define TSSO_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsso assertion failed");
// Next-cycle implication.
`define TSSO_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsso assertion failed");
`else
`define TSSO_ASSERT_IMP(label, clk, rst, ante, cons)
`define TSSO_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/tsso_pkg.sv */
`timescale 1ns / 1ps
package tsso_pkg;

  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  localparam int CMD_W     = 3;
  localparam int ADDR_W    = 12;
  localparam int DATA_W    = 8;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [DATA_W-1:0] HIGHLIGHT_RESET    = 8'd112;
  localparam logic [DATA_W-1:0] DEFAULT_ATTR_RESET = 8'd7;
  localparam logic [ADDR_W-1:0] CURSOR_POS_RESET   = 12'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 3'd0,
    CMD_FETCH    = 3'd1,
    CMD_CUR_SHOW = 3'd2,
    CMD_CUR_HIDE = 3'd3,
    CMD_SEL_SHOW = 3'd4,
    CMD_SEL_HIDE = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGHLIGHT_ATTR = 1'b0,
    REG_DEFAULT_ATTR   = 1'b1
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic wr_byte;
    logic rd_ptr;
    logic rd_cur;
    logic cur_set;
    logic cur_hide;
    logic sel_load;
    logic sel_init;
    logic sel_rd;
    logic sel_wr;
    logic sel_show;
    logic out_push;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t command;
    logic clear_last;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/tsso_if.sv */
`timescale 1ns / 1ps
interface tsso_in_if import tsso_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data_byte;
  logic [COL_W-1:0]  start_col;
  logic [ROW_W-1:0]  start_row;
  logic [COL_W-1:0]  end_col;
  logic [ROW_W-1:0]  end_row;

  modport source (
    output valid, command, address, data_byte, start_col, start_row, end_col, end_row,
    input  ready
  );
  modport sink (
    input  valid, command, address, data_byte, start_col, start_row, end_col, end_row,
    output ready
  );
endinterface

interface tsso_out_if import tsso_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

/* rtl/tsso_ctrl.sv */
`timescale 1ns / 1ps
module tsso_ctrl import tsso_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_EXEC     = 8'b0000_0100,
    S_CUR_WR   = 8'b0000_1000,
    S_SEL_INIT = 8'b0001_0000,
    S_SEL_RD   = 8'b0010_0000,
    S_SEL_WR   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (stat.command)
          CMD_WRITE:    cmd.wr_byte = 1'b1;
          CMD_FETCH:    cmd.rd_ptr = 1'b1;
          CMD_CUR_SHOW: begin
            cmd.rd_cur = 1'b1;
            state_next = S_CUR_WR;
          end
          CMD_CUR_HIDE: cmd.cur_hide = 1'b1;
          CMD_SEL_SHOW: begin
            cmd.sel_load = 1'b1;
            state_next   = S_SEL_INIT;
          end
          CMD_SEL_HIDE: state_next = S_SEL_INIT;
          default:      state_next = S_DONE;
        endcase
      end
      S_CUR_WR: begin
        cmd.cur_set = 1'b1;
        state_next  = S_DONE;
      end
      S_SEL_INIT: begin
        cmd.sel_init = 1'b1;
        state_next   = S_SEL_RD;
      end
      S_SEL_RD: begin
        cmd.sel_rd = 1'b1;
        state_next = S_SEL_WR;
      end
      S_SEL_WR: begin
        cmd.sel_wr   = 1'b1;
        cmd.sel_show = (stat.command == CMD_SEL_SHOW);
        state_next   = stat.walk_last ? S_DONE : S_SEL_RD;
      end
      S_DONE: begin
        // result leaves and the next item may come in the same cycle
        if (stat.out_free) begin
          cmd.out_push = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_EXEC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

/* rtl/tsso_datapath.sv */
`timescale 1ns / 1ps
module tsso_datapath import tsso_pkg::*; #(
  parameter int COLUMNS = DEFAULT_COLUMNS,
  parameter int ROWS    = DEFAULT_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic [CMD_W-1:0]     command,
  input  logic [ADDR_W-1:0]    address,
  input  logic [DATA_W-1:0]    data_byte,
  input  logic [COL_W-1:0]     start_col,
  input  logic [ROW_W-1:0]     start_row,
  input  logic [COL_W-1:0]     end_col,
  input  logic [ROW_W-1:0]     end_row,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [DATA_W-1:0]    out_data,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat
);
  `include "text_screen_selection_overlay_assert.svh"

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int MEM_BYTES = 2 * CELLS;
  localparam int CELL_AW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int MEM_AW    = CELL_AW + 1;

  // configuration
  logic [DATA_W-1:0] highlight_attr;
  logic [DATA_W-1:0] default_attr;

  always_ff @(posedge clk) begin
    if (rst) begin
      highlight_attr <= HIGHLIGHT_RESET;
      default_attr   <= DEFAULT_ATTR_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_HIGHLIGHT_ATTR: highlight_attr <= cfg_data;
        REG_DEFAULT_ATTR:   default_attr <= cfg_data;
        default: ;
      endcase
    end
  end

  // held input item
  cmd_t              cmd_q;
  logic [ADDR_W-1:0] address_q;
  logic [DATA_W-1:0] data_q;
  logic [COL_W-1:0]  start_col_q, end_col_q;
  logic [ROW_W-1:0]  start_row_q, end_row_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q       <= cmd_t'(command);
      address_q   <= address;
      data_q      <= data_byte;
      start_col_q <= start_col;
      start_row_q <= start_row;
      end_col_q   <= end_col;
      end_row_q   <= end_row;
    end
  end

  logic addr_ok;
  assign addr_ok = (32'(address_q) < MEM_BYTES);

  // block state
  logic [MEM_AW-1:0] read_pointer;
  logic [MEM_AW-1:0] clr_cnt;
  logic [ADDR_W-1:0] cursor_position;
  logic [DATA_W-1:0] cursor_saved_attr;
  logic [COL_W-1:0]  sel_start_col, sel_end_col;
  logic [ROW_W-1:0]  sel_start_row, sel_end_row;
  logic              cursor_ok;

  assign cursor_ok = (32'(cursor_position) < MEM_BYTES);

  // rectangle bounds
  logic [COL_W-1:0]   c0, c1, cur_col;
  logic [ROW_W-1:0]   r0, r1, cur_row;
  logic [CELL_AW-1:0] cell_idx;

  assign c0 = (sel_start_col < sel_end_col) ? sel_start_col : sel_end_col;
  assign c1 = (sel_start_col < sel_end_col) ? sel_end_col : sel_start_col;
  assign r0 = (sel_start_row < sel_end_row) ? sel_start_row : sel_end_row;
  assign r1 = (sel_start_row < sel_end_row) ? sel_end_row : sel_start_row;

  // memories
  logic [DATA_W-1:0]  disp_mem [MEM_BYTES];
  logic [DATA_W-1:0]  backup_mem [CELLS];
  logic [DATA_W-1:0]  disp_rdata, backup_rdata;
  logic               disp_re, disp_we, backup_we;
  logic [MEM_AW-1:0]  disp_ra, disp_wa;
  logic [DATA_W-1:0]  disp_wd, backup_wd, saved_form;
  logic [CELL_AW-1:0] backup_wa;

  // attribute as saved for later restore; zero becomes the default
  assign saved_form = (disp_rdata != '0) ? disp_rdata : default_attr;

  always_comb begin
    disp_re = cmd.rd_ptr | cmd.rd_cur | cmd.sel_rd;
    disp_ra = read_pointer;
    if (cmd.rd_cur) disp_ra = MEM_AW'(address_q);
    else if (cmd.sel_rd) disp_ra = {cell_idx, 1'b1};

    disp_we = 1'b0;
    disp_wa = {cell_idx, 1'b1};
    disp_wd = highlight_attr;
    if (cmd.clr_step) begin
      disp_we = 1'b1;
      disp_wa = clr_cnt;
      disp_wd = '0;
    end else if (cmd.wr_byte) begin
      disp_we = addr_ok;
      disp_wa = MEM_AW'(address_q);
      disp_wd = data_q;
    end else if (cmd.cur_set) begin
      disp_we = addr_ok;
      disp_wa = MEM_AW'(address_q);
      disp_wd = highlight_attr;
    end else if (cmd.cur_hide) begin
      disp_we = cursor_ok;
      disp_wa = MEM_AW'(cursor_position);
      disp_wd = cursor_saved_attr;
    end else if (cmd.sel_wr) begin
      disp_we = 1'b1;
      disp_wd = cmd.sel_show ? highlight_attr : backup_rdata;
    end

    // clearing pass covers each backup entry twice, from byte counter / 2
    backup_we = cmd.clr_step | (cmd.sel_wr & cmd.sel_show);
    backup_wa = cmd.clr_step ? clr_cnt[MEM_AW-1:1] : cell_idx;
    if (cmd.clr_step) begin
      backup_wd = (clr_cnt[MEM_AW-1:1] == '0) ? DEFAULT_ATTR_RESET : '0;
    end else begin
      backup_wd = saved_form;
    end
  end

  always_ff @(posedge clk) begin
    if (disp_we) disp_mem[disp_wa] <= disp_wd;
  end

  always_ff @(posedge clk) begin
    if (disp_re) disp_rdata <= disp_mem[disp_ra];
  end

  always_ff @(posedge clk) begin
    if (backup_we) backup_mem[backup_wa] <= backup_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_rd) backup_rdata <= backup_mem[cell_idx];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer      <= '0;
      clr_cnt           <= '0;
      cursor_position   <= CURSOR_POS_RESET;
      cursor_saved_attr <= DEFAULT_ATTR_RESET;
      sel_start_col     <= '0;
      sel_start_row     <= '0;
      sel_end_col       <= '0;
      sel_end_row       <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.rd_ptr) begin
        read_pointer <= (read_pointer == MEM_AW'(MEM_BYTES - 1)) ? '0
                                                                 : read_pointer + 1'b1;
      end
      if (cmd.cur_set) begin
        cursor_position   <= address_q;
        cursor_saved_attr <= addr_ok ? saved_form : default_attr;
      end
      if (cmd.sel_load) begin
        sel_start_col <= (32'(start_col_q) < COLUMNS) ? start_col_q : COL_W'(COLUMNS - 1);
        sel_start_row <= (32'(start_row_q) < ROWS) ? start_row_q : ROW_W'(ROWS - 1);
        sel_end_col   <= (32'(end_col_q) < COLUMNS) ? end_col_q : COL_W'(COLUMNS - 1);
        sel_end_row   <= (32'(end_row_q) < ROWS) ? end_row_q : ROW_W'(ROWS - 1);
      end
    end
  end

  // rectangle walk, row by row
  always_ff @(posedge clk) begin
    if (cmd.sel_init) begin
      cur_col  <= c0;
      cur_row  <= r0;
      cell_idx <= CELL_AW'(32'(r0) * COLUMNS + 32'(c0));
    end else if (cmd.sel_wr) begin
      if (cur_col == c1) begin
        cur_col  <= c0;
        cur_row  <= cur_row + 1'b1;
        cell_idx <= cell_idx + CELL_AW'(COLUMNS) - CELL_AW'(c1 - c0);
      end else begin
        cur_col  <= cur_col + 1'b1;
        cell_idx <= cell_idx + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_push) out_data <= (cmd_q == CMD_FETCH) ? disp_rdata : '0;
  end

  assign stat.command    = cmd_q;
  assign stat.clear_last = (clr_cnt == MEM_AW'(MEM_BYTES - 1));
  assign stat.walk_last  = (cur_col == c1) && (cur_row == r1);
  assign stat.out_free   = !out_valid || out_ready;

  `TSSO_ASSERT_IMP(a_walk_in_rect, clk, rst, cmd.sel_wr,
                   cur_col >= c0 && cur_col <= c1 && cur_row >= r0 && cur_row <= r1)
  `TSSO_ASSERT_IMP(a_cell_matches, clk, rst, cmd.sel_rd,
                   cell_idx == CELL_AW'(32'(cur_row) * COLUMNS + 32'(cur_col)))
  `TSSO_ASSERT_IMP(a_ptr_in_mem, clk, rst, 1'b1, 32'(read_pointer) < MEM_BYTES)
  `TSSO_ASSERT_NXT(a_push_lands, clk, rst, cmd.out_push, out_valid)

endmodule

/* rtl/text_screen_selection_overlay.sv */
`timescale 1ns / 1ps
// Text screen with selection overlay: a COLUMNS x ROWS display memory of character/attribute
// byte pairs with byte write, sequential fetch, a one-cell mouse cursor and a rectangular
// selection highlight. One result per accepted command; read_data is zero except for fetch.
// After reset a clearing pass over all 2*COLUMNS*ROWS bytes (4000 at 80x25) runs before the first
// command is taken; configuration writes are taken at any time. Write, fetch, hide cursor and
// unused codes run an execute step then a done step; show cursor adds a write step between
// them, and show or hide selection adds an init step, then a read and a write for every cell
// of the rectangle through the single-port-per-side display and backup memories. A finished
// result sits in an output register while the next command comes in.
module text_screen_selection_overlay import tsso_pkg::*; #(
  parameter int COLUMNS = DEFAULT_COLUMNS,
  parameter int ROWS    = DEFAULT_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  tsso_in_if.sink              cmd_in,
  tsso_out_if.source           res_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_in.valid),
    .in_ready (cmd_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsso_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (cmd_in.command),
    .address   (cmd_in.address),
    .data_byte (cmd_in.data_byte),
    .start_col (cmd_in.start_col),
    .start_row (cmd_in.start_row),
    .end_col   (cmd_in.end_col),
    .end_row   (cmd_in.end_row),
    .out_ready (res_out.ready),
    .out_valid (res_out.valid),
    .out_data  (res_out.read_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
